// ===== sv/tlpq_pkg.sv =====
// Shared constants, level and operation codes, and command type for the priority queue.
package tlpq_pkg;

    localparam int NUM_LEVELS       = 3;
    localparam int LEVEL_W          = 2;
    localparam int HANDLE_BITS      = 32;
    localparam int DEF_DEPTH        = 16;
    localparam int DEF_HANDLE_WIDTH = 32;

    localparam logic [LEVEL_W-1:0] LVL_HIGH = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_MED  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_LOW  = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_ALT  = 2'd3;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic enq;
        logic deq;
        logic load_rd;
    } tlpq_cmd_t;

endpackage

// ===== sv/tlpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tlpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tlpq_ctrl.sv =====
// Handshake controller: accepts transactions and sequences the dequeue read.
module tlpq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 op,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output tlpq_pkg::tlpq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign cmd.enq     = accept && (op == tlpq_pkg::OP_ENQ);
    assign cmd.deq     = accept && (op == tlpq_pkg::OP_DEQ);
    assign cmd.load_rd = (state_reg == ST_READ) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.deq)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (cmd.load_rd)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.enq || cmd.load_rd)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ===== sv/tlpq_datapath.sv =====
// Level pointers, occupancy counters, handle memories and result registers.
module tlpq_datapath #(
    parameter int DEPTH        = tlpq_pkg::DEF_DEPTH,
    parameter int HANDLE_WIDTH = tlpq_pkg::DEF_HANDLE_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tlpq_pkg::tlpq_cmd_t                 cmd,
    input  logic [tlpq_pkg::HANDLE_BITS-1:0]    handle,
    input  logic [tlpq_pkg::LEVEL_W-1:0]        level,
    output logic                                found,
    output logic [tlpq_pkg::HANDLE_BITS-1:0]    out_handle,
    output logic [tlpq_pkg::LEVEL_W-1:0]        out_level,
    output logic                                dropped,
    output logic                                all_empty
);

    localparam int NL      = tlpq_pkg::NUM_LEVELS;
    localparam int LW      = tlpq_pkg::LEVEL_W;
    localparam int HB      = tlpq_pkg::HANDLE_BITS;
    localparam int STORE_W = (HANDLE_WIDTH < HB) ? HANDLE_WIDTH : HB;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [CNT_W-1:0]   count_reg [NL];
    logic [CNT_W-1:0]   count_next [NL];
    logic [PTR_W-1:0]   rptr_reg [NL];
    logic [PTR_W-1:0]   rptr_next [NL];
    logic [PTR_W-1:0]   wptr_reg [NL];
    logic [PTR_W-1:0]   wptr_next [NL];
    logic [STORE_W-1:0] rd_data [NL];
    logic [NL-1:0]      ram_we;
    logic [NL-1:0]      ram_re;

    logic [LW-1:0]      lv_enq;
    logic [LW-1:0]      lv_deq;
    logic               enq_full;
    logic               deq_any;
    logic               empty_next;

    logic               pend_found_reg;
    logic [LW-1:0]      pend_lvl_reg;
    logic               pend_empty_reg;

    logic               found_reg;
    logic [HB-1:0]      handle_reg;
    logic [LW-1:0]      level_reg;
    logic               dropped_reg;
    logic               empty_reg;

    always_comb
    begin
        lv_enq   = (level == tlpq_pkg::LVL_ALT) ? tlpq_pkg::LVL_LOW : level;
        enq_full = (count_reg[lv_enq] == CNT_W'(DEPTH));
        deq_any  = (count_reg[0] != '0) || (count_reg[1] != '0) || (count_reg[2] != '0);
        if (count_reg[0] != '0)
        begin
            lv_deq = tlpq_pkg::LVL_HIGH;
        end
        else if (count_reg[1] != '0)
        begin
            lv_deq = tlpq_pkg::LVL_MED;
        end
        else
        begin
            lv_deq = tlpq_pkg::LVL_LOW;
        end

        for (int i = 0; i < NL; i++)
        begin
            count_next[i] = count_reg[i];
            rptr_next[i]  = rptr_reg[i];
            wptr_next[i]  = wptr_reg[i];
        end
        if (cmd.enq && !enq_full)
        begin
            wptr_next[lv_enq]  = bump(wptr_reg[lv_enq]);
            count_next[lv_enq] = count_reg[lv_enq] + 1'b1;
        end
        if (cmd.deq && deq_any)
        begin
            rptr_next[lv_deq]  = bump(rptr_reg[lv_deq]);
            count_next[lv_deq] = count_reg[lv_deq] - 1'b1;
        end
        empty_next = (count_next[0] == '0) && (count_next[1] == '0) && (count_next[2] == '0);
    end

    for (genvar g = 0; g < NL; g++)
    begin : g_level
        assign ram_we[g] = cmd.enq && !enq_full && (lv_enq == LW'(g));
        assign ram_re[g] = cmd.deq && deq_any && (lv_deq == LW'(g));

        tlpq_ram #(
            .WIDTH (STORE_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[g]),
            .waddr (wptr_reg[g]),
            .wdata (handle[STORE_W-1:0]),
            .re    (ram_re[g]),
            .raddr (rptr_reg[g]),
            .rdata (rd_data[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NL; i++)
            begin
                count_reg[i] <= '0;
                rptr_reg[i]  <= '0;
                wptr_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NL; i++)
            begin
                count_reg[i] <= count_next[i];
                rptr_reg[i]  <= rptr_next[i];
                wptr_reg[i]  <= wptr_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.deq)
        begin
            pend_found_reg <= deq_any;
            pend_lvl_reg   <= lv_deq;
            pend_empty_reg <= empty_next;
        end
        if (cmd.enq)
        begin
            found_reg   <= 1'b0;
            handle_reg  <= '0;
            level_reg   <= tlpq_pkg::LVL_LOW;
            dropped_reg <= enq_full;
            empty_reg   <= empty_next;
        end
        else if (cmd.load_rd)
        begin
            found_reg   <= pend_found_reg;
            handle_reg  <= pend_found_reg ? HB'(rd_data[pend_lvl_reg]) : '0;
            level_reg   <= pend_found_reg ? pend_lvl_reg : tlpq_pkg::LVL_LOW;
            dropped_reg <= 1'b0;
            empty_reg   <= pend_empty_reg;
        end
    end

    assign found      = found_reg;
    assign out_handle = handle_reg;
    assign out_level  = level_reg;
    assign dropped    = dropped_reg;
    assign all_empty  = empty_reg;

endmodule

// ===== sv/three_level_priority_queue.sv =====
// Top level of the three-level strict-priority queue of handles.
//
// Slave channel: one transaction is an enqueue (op 0) of a handle to a level,
// or a dequeue (op 1) of the oldest handle at the highest non-empty level.
// Level code three is taken as low. Each transaction yields exactly one
// result transaction on the master channel, carrying found, the handle, its
// level, a drop flag for an enqueue to a full level, and whether all levels
// are empty afterward.
// An enqueue result is registered in the cycle after acceptance; a dequeue
// result comes through the registered read port of the level memory and
// then the result register. While the receiver keeps up, the queue takes one
// enqueue per cycle; a dequeue blocks new transactions until its read is done.
// Reset empties all levels at once; stored handles are not cleared.
// When the receiver stalls, the result holds in the output register and one
// more transaction is taken only once that register drains.
module three_level_priority_queue #(
    parameter int DEPTH        = tlpq_pkg::DEF_DEPTH,
    parameter int HANDLE_WIDTH = tlpq_pkg::DEF_HANDLE_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // handle[31:0]
    input  logic [2:0]  s_tuser,   // op[0], level[2:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_handle[31:0]
    output logic [4:0]  m_tuser    // found[0], out_level[2:1], dropped[3], all_empty[4]
);

    tlpq_pkg::tlpq_cmd_t cmd;
    logic                found;
    logic [1:0]          out_level;
    logic                dropped;
    logic                all_empty;

    tlpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tlpq_datapath #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .handle     (s_tdata),
        .level      (s_tuser[2:1]),
        .found      (found),
        .out_handle (m_tdata),
        .out_level  (out_level),
        .dropped    (dropped),
        .all_empty  (all_empty)
    );

    assign m_tuser = {all_empty, dropped, out_level, found};

`ifndef NO_ASSERTIONS
    a_deq_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deq |=> !s_tready)
        else $error("input taken during dequeue read");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_rd |=> m_tvalid)
        else $error("dequeue result not presented");

    a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && dropped) |-> !all_empty)
        else $error("drop reported with all levels empty");

    a_found_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && found) |-> (!dropped && out_level != tlpq_pkg::LVL_ALT))
        else $error("bad dequeue result flags");
`endif

endmodule
